// File: hdl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by fpa_div_pipe, fixed_point_alu_q24_8_unit and its testbench.
package fpa_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_MUL   = 4'd1,
        FN_DIV   = 4'd2,
        FN_EQ    = 4'd3,
        FN_NE    = 4'd4,
        FN_LT    = 4'd5,
        FN_LE    = 4'd6,
        FN_GT    = 4'd7,
        FN_GE    = 4'd8,
        FN_MIN   = 4'd9,
        FN_MAX   = 4'd10,
        FN_INC   = 4'd11,
        FN_DEC   = 4'd12,
        FN_TOINT = 4'd13
    } t_func;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MUL_OVF  = 3'd1,
        ERR_DIV_ZERO = 3'd2,
        ERR_DIV_OVF  = 3'd3,
        ERR_ADD_OVF  = 3'd4
    } t_err;

    // Everything that travels beside the divider for one transaction.
    typedef struct packed {
        logic [3:0]        func;
        logic [WORD_W-1:0] simple_res;
        logic              cmp;
        logic [WORD_W-1:0] add_res;
        logic              add_ovf;
        logic [63:0]       product;
        logic              div_neg;
        logic              div_zero;
    } t_side;

endpackage

// File: hdl/fpa_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on fpa_pkg for WORD_W; carries an opaque sideband word along.
module fpa_div_pipe
    import fpa_pkg::*;
#(
    parameter int DW  = 40,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [DW-1:0]     o_quotient,
    output logic [SBW-1:0]    o_side
);

    logic              r_v   [DW];
    logic [WORD_W-1:0] r_rem [DW];
    logic [DW-1:0]     r_z   [DW];
    logic [WORD_W-1:0] r_d   [DW];
    logic [SBW-1:0]    r_sb  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic              p_v;
        logic [WORD_W-1:0] p_rem;
        logic [DW-1:0]     p_z;
        logic [WORD_W-1:0] p_d;
        logic [SBW-1:0]    p_sb;
        logic [WORD_W:0]   sh;
        logic              ge;
        logic [WORD_W-1:0] n_rem;
        logic [DW-1:0]     n_z;

        // Previous stage, or the pipeline input for the first stage.
        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = '0;
            assign p_z   = i_dividend;
            assign p_d   = i_divisor;
            assign p_sb  = i_side;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_z   = r_z[k-1];
            assign p_d   = r_d[k-1];
            assign p_sb  = r_sb[k-1];
        end

        // One trial subtraction; the quotient bit shifts in as the dividend shifts out.
        always_comb begin
            sh    = {p_rem, p_z[DW-1]};
            ge    = (sh >= {1'b0, p_d});
            n_rem = ge ? WORD_W'(sh - {1'b0, p_d}) : sh[WORD_W-1:0];
            n_z   = {p_z[DW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
            r_rem[k] <= n_rem;
            r_z[k]   <= n_z;
            r_d[k]   <= p_d;
            r_sb[k]  <= p_sb;
        end
    end

    assign o_valid    = r_v[DW-1];
    assign o_quotient = r_z[DW-1];
    assign o_side     = r_sb[DW-1];

endmodule

// File: hdl/fixed_point_alu_q24_8_unit.sv
// Top level of the signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// Depends on fpa_pkg and instantiates fpa_div_pipe.
//
// Usage:
// A transaction is accepted at a rising edge where i_start is high and
// o_busy is low. o_busy is held low, so one transaction may enter on every
// clock cycle. Each transaction carries i_func, i_operand_a and i_operand_b.
// Its result appears on o_result_raw, o_compare_true and o_error_code for
// exactly one cycle, marked by o_valid, in the order of acceptance.
// Every operation passes one input register, 32 + FRAC_BITS divider stages
// and one output register. All operations travel through the divider's
// one-quotient-bit-per-stage pipeline so that results keep their order.
// Throughput is one transaction per cycle.
// A synchronous active-low reset clears all valid bits, dropping any
// transactions in flight. The receiver cannot stall, so nothing is held back.
module fixed_point_alu_q24_8_unit
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [3:0]        i_func,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic              o_valid,
    output logic signed [31:0] o_result_raw,
    output logic              o_compare_true,
    output logic [2:0]        o_error_code
);

    localparam int DW  = WORD_W + FRAC_BITS;
    localparam int SBW = $bits(t_side);

    // Input register.
    logic              r_in_v;
    logic [3:0]        r_func;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= i_start;
        end
        r_func <= i_func;
        r_a    <= i_operand_a;
        r_b    <= i_operand_b;
    end

    // Front-end: simple operations, add, multiply and divider operands.
    t_side             side_in;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] abs_a;
    logic [WORD_W-1:0] abs_b;
    logic [DW-1:0]     dividend;
    logic signed [31:0] a_shr;

    always_comb begin
        side_in          = '0;
        side_in.func     = r_func;
        a_shr            = r_a >>> FRAC_BITS;
        case (r_func)
            FN_EQ:    side_in.cmp = (r_a == r_b);
            FN_NE:    side_in.cmp = (r_a != r_b);
            FN_LT:    side_in.cmp = (r_a < r_b);
            FN_LE:    side_in.cmp = (r_a <= r_b);
            FN_GT:    side_in.cmp = (r_a > r_b);
            FN_GE:    side_in.cmp = (r_a >= r_b);
            FN_MIN:   side_in.simple_res = (r_a < r_b) ? r_a : r_b;
            FN_MAX:   side_in.simple_res = (r_a > r_b) ? r_a : r_b;
            FN_INC:   side_in.simple_res = r_a + 32'sd1;
            FN_DEC:   side_in.simple_res = r_a - 32'sd1;
            FN_TOINT: side_in.simple_res = a_shr;
            default:  side_in.simple_res = '0;
        endcase
        sum              = {r_a[31], r_a} + {r_b[31], r_b};
        side_in.add_res  = sum[WORD_W-1:0];
        side_in.add_ovf  = (sum[WORD_W] != sum[WORD_W-1]);
        side_in.div_neg  = r_a[31] ^ r_b[31];
        side_in.div_zero = (r_b == 32'sd0);
        abs_a            = r_a[31] ? WORD_W'(-r_a) : r_a;
        abs_b            = r_b[31] ? WORD_W'(-r_b) : r_b;
        dividend         = DW'(abs_a) << FRAC_BITS;
    end

    // Multiply in 64 bits so the product is exact.
    logic signed [63:0] prod_wide;
    assign prod_wide = 64'(r_a) * 64'(r_b);

    t_side side_ld;
    always_comb begin
        side_ld         = side_in;
        side_ld.product = prod_wide;
    end

    // Divider pipeline, which also carries the sideband.
    logic            dv_valid;
    logic [DW-1:0]   dv_q;
    logic [SBW-1:0]  dv_side_bits;
    t_side           side_out;

    fpa_div_pipe #(
        .DW  (DW),
        .SBW (SBW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_v),
        .i_dividend (dividend),
        .i_divisor  (abs_b),
        .i_side     (side_ld),
        .o_valid    (dv_valid),
        .o_quotient (dv_q),
        .o_side     (dv_side_bits)
    );

    assign side_out = t_side'(dv_side_bits);

    // Back-end: signs, range checks and result selection.
    logic [63:0]        q64;
    logic signed [63:0] mul_t;
    logic               mul_ovf;
    logic               div_ovf;
    logic [31:0]        div_res;
    logic [31:0]        n_result;
    logic               n_cmp;
    logic [2:0]         n_err;

    always_comb begin
        q64     = 64'(dv_q);
        mul_t   = $signed(side_out.product) >>> FRAC_BITS;
        mul_ovf = (mul_t[63:31] != {33{mul_t[31]}});
        div_ovf = side_out.div_neg ? (q64 > 64'h8000_0000) : (q64 > 64'h7FFF_FFFF);
        div_res = side_out.div_neg ? 32'(-q64) : q64[31:0];
        n_result = side_out.simple_res;
        n_cmp    = side_out.cmp;
        n_err    = ERR_NONE;
        case (side_out.func)
            FN_ADD: begin
                n_result = side_out.add_ovf ? '0 : side_out.add_res;
                n_err    = side_out.add_ovf ? ERR_ADD_OVF : ERR_NONE;
            end
            FN_MUL: begin
                n_result = mul_ovf ? '0 : mul_t[31:0];
                n_err    = mul_ovf ? ERR_MUL_OVF : ERR_NONE;
            end
            FN_DIV: begin
                if (side_out.div_zero) begin
                    n_result = '0;
                    n_err    = ERR_DIV_ZERO;
                end else if (div_ovf) begin
                    n_result = '0;
                    n_err    = ERR_DIV_OVF;
                end else begin
                    n_result = div_res;
                end
            end
            default: begin
                n_err = ERR_NONE;
            end
        endcase
    end

    // Output register.
    logic        r_valid;
    logic [31:0] r_result;
    logic        r_cmp;
    logic [2:0]  r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dv_valid;
        end
        r_result <= n_result;
        r_cmp    <= n_cmp;
        r_err    <= n_err;
    end

    assign o_valid        = r_valid;
    assign o_result_raw   = r_result;
    assign o_compare_true = r_cmp;
    assign o_error_code   = r_err;

endmodule

// File: bench/fixed_point_alu_q24_8_unit_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU (fixed_point_alu_q24_8_unit).
// Depends on fpa_pkg and the RTL; predicts every result in-line and checks them in order.
module fixed_point_alu_q24_8_unit_tb
    import fpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC   = 8;
    localparam int LAT    = 34 + FRAC;
    localparam int LIMIT  = 200000;
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;

    typedef struct {
        logic [3:0]         func;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_op;

    typedef struct {
        logic signed [31:0] res;
        logic               cmp;
        logic [2:0]         err;
    } t_alu_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [3:0]         i_func = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_busy;
    logic               o_valid;
    logic signed [31:0] o_result_raw;
    logic               o_compare_true;
    logic [2:0]         o_error_code;

    t_op      pending_ops[$];
    t_alu_out expected_outs[$];
    int       idle_pct = 38;
    bit       hold_off = 1'b0;
    bit       feeding = 1'b0;
    int       fail_count = 0;
    int       checked_count = 0;
    int       error_results = 0;
    longint   cycle_count = 0;

    fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC)) i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Arithmetic result of one ALU transaction.
    function automatic t_alu_out alu_predict(t_op op);
        t_alu_out o;
        longint sa, sb, t;
        o = '{res: '0, cmp: 1'b0, err: ERR_NONE};
        sa = op.a;
        sb = op.b;
        case (op.func)
            FN_ADD: begin
                t = sa + sb;
                if (t > W_MAX || t < W_MIN) o.err = ERR_ADD_OVF;
                else o.res = t[31:0];
            end
            FN_MUL: begin
                t = (sa * sb) >>> FRAC;
                if (t > W_MAX || t < W_MIN) o.err = ERR_MUL_OVF;
                else o.res = t[31:0];
            end
            FN_DIV: begin
                if (sb == 0) begin
                    o.err = ERR_DIV_ZERO;
                end else begin
                    t = (sa * (64'sd1 << FRAC)) / sb;
                    if (t > W_MAX || t < W_MIN) o.err = ERR_DIV_OVF;
                    else o.res = t[31:0];
                end
            end
            FN_EQ:    o.cmp = (sa == sb);
            FN_NE:    o.cmp = (sa != sb);
            FN_LT:    o.cmp = (sa < sb);
            FN_LE:    o.cmp = (sa <= sb);
            FN_GT:    o.cmp = (sa > sb);
            FN_GE:    o.cmp = (sa >= sb);
            FN_MIN:   o.res = (sa < sb) ? op.a : op.b;
            FN_MAX:   o.res = (sa > sb) ? op.a : op.b;
            FN_INC:   o.res = op.a + 32'sd1;
            FN_DEC:   o.res = op.a - 32'sd1;
            FN_TOINT: o.res = op.a >>> FRAC;
            default: ;
        endcase
        return o;
    endfunction

    // Operands biased towards extremes, small values and exact Q24.8 numbers.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000}
                      ^ $urandom_range(0, 3);
            1: return $signed($urandom_range(0, 2048)) - 32'sd1024;
            2: return $signed($urandom_range(0, 65535) - 32768) <<< FRAC;
            3: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [3:0] f, logic [31:0] a, logic [31:0] b);
        pending_ops.push_back('{func: f, a: a, b: b});
    endtask

    // Driver: offers the next pending transaction, idling at random.
    // An accepted transaction leaves the queue first, so the head is always the next one.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_start && !o_busy) begin
            expected_outs.push_back(alu_predict(pending_ops.pop_front()));
        end
        if (i_rst_n && feeding && !hold_off && pending_ops.size() > 0
            && $urandom_range(0, 99) >= idle_pct) begin
            i_start <= 1'b1;
            i_func <= pending_ops[0].func;
            i_operand_a <= pending_ops[0].a;
            i_operand_b <= pending_ops[0].b;
        end else if (!(i_start && o_busy)) begin
            i_start <= 1'b0;
        end
    end

    // Monitor: compares each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_alu_out exp_out;
        if (i_rst_n && o_valid) begin
            if (expected_outs.size() == 0) begin
                $error("unexpected result %0d", o_result_raw);
                fail_count++;
            end else begin
                exp_out = expected_outs.pop_front();
                checked_count <= checked_count + 1;
                if (exp_out.err != ERR_NONE) error_results <= error_results + 1;
                if (o_result_raw !== exp_out.res) begin
                    $error("result_raw: expected %0d, got %0d", exp_out.res, o_result_raw);
                    fail_count++;
                end
                if (o_compare_true !== exp_out.cmp) begin
                    $error("compare_true: expected %0b, got %0b",
                           exp_out.cmp, o_compare_true);
                    fail_count++;
                end
                if (o_error_code !== exp_out.err) begin
                    $error("error_code: expected %0d, got %0d", exp_out.err, o_error_code);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a stuck pipeline.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_random(int n);
        logic [3:0] f;
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            f = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(14, 15))
                                             : 4'($urandom_range(FN_ADD, FN_TOINT));
            a = pick_operand();
            // Equal operands now and then for comparisons, min and max.
            queue_op(f, a, ($urandom_range(0, 7) == 0) ? a
                           : ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
        end
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_outs.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        feeding = 1'b1;

        // Directed: every operation, field extremes and the named corner cases.
        queue_op(FN_ADD, 32'h7FFF_FFFF, 32'h1);
        queue_op(FN_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_op(FN_MUL, 32'hFFFF_FF80, 32'h0000_0180);
        queue_op(FN_MUL, 32'h8000_0000, 32'h0000_0100);
        queue_op(FN_DIV, 32'h0000_1234, 32'h0);
        queue_op(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(FN_DIV, 32'hFFFF_FD00, 32'h0000_0200);
        queue_op(FN_DIV, 32'h0000_0001, 32'hFFFF_FFFD);
        queue_op(FN_EQ, 32'h5, 32'h5);
        queue_op(FN_NE, 32'h5, 32'h6);
        queue_op(FN_LT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(FN_LE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_op(FN_GT, 32'hFFFF_FFFF, 32'h0);
        queue_op(FN_GE, 32'h0, 32'hFFFF_FFFF);
        queue_op(FN_MIN, 32'hABCD, 32'hABCD);
        queue_op(FN_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(FN_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FN_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(FN_TOINT, 32'hFFFF_FF01, 32'h0);
        queue_op(FN_TOINT, 32'h7FFF_FFFF, 32'h0);
        queue_op(4'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(4'd15, 32'h1, 32'h2);
        drain();

        // Pause with nothing in flight, then three idling profiles.
        hold_off = 1'b1;
        repeat (LAT + 4) @(posedge i_clk);
        hold_off = 1'b0;
        idle_pct = 38;
        queue_random(350);
        drain();
        idle_pct = 74;
        queue_random(350);
        drain();
        idle_pct = 0;
        queue_random(350);
        drain();
        repeat (LAT + 8) @(posedge i_clk);

        $display("Checked %0d results over all 14 operations and unused codes,",
                 checked_count);
        $display("%0d of them overflow or divide-by-zero errors.", error_results);
        if (fail_count == 0 && expected_outs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
